@@ sv/csd_pkg.sv @@
// ----------------------------------------------------------------------------
// csd_pkg: shared definitions for the card shuffle and draw block
// Field widths, operation and status codes, remainder unit sizing.
// ----------------------------------------------------------------------------
package csd_pkg;

    localparam int NUM_CARDS_DEF = 52;

    localparam int OP_W     = 2;
    localparam int WORD_W   = 31;
    localparam int CODE_W   = 6;
    localparam int LEFT_W   = 6;
    localparam int PASS_W   = 4;
    localparam int STATUS_W = 2;

    localparam logic [PASS_W-1:0] PASSES_RESET = PASS_W'(9);

    // operation codes
    localparam logic [OP_W-1:0] OP_NEW     = 2'd0;
    localparam logic [OP_W-1:0] OP_SHUFFLE = 2'd1;
    localparam logic [OP_W-1:0] OP_DRAW    = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd2;

    // remainder unit: bits retired per cycle and resulting number of steps
    localparam int REM_RADIX_BITS = 4;
    localparam int REM_STEPS      = (WORD_W + REM_RADIX_BITS - 1) / REM_RADIX_BITS;
    localparam int REM_PAD_W      = REM_STEPS * REM_RADIX_BITS;
    localparam int REM_CNT_W      = (REM_STEPS > 1) ? $clog2(REM_STEPS) : 1;

endpackage

@@ sv/csd_ifs.sv @@
// ----------------------------------------------------------------------------
// csd_ifs: channel interfaces of the card shuffle and draw block
// Request, response and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface csd_in_if import csd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [WORD_W-1:0]   random_word;

    modport source (output valid, output operation, output random_word, input ready);
    modport sink   (input valid, input operation, input random_word, output ready);
endinterface

interface csd_out_if import csd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CODE_W-1:0]   card_code;
    logic                card_valid;
    logic [LEFT_W-1:0]   cards_left;
    logic                shuffle_done;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output card_code, output card_valid, output cards_left,
                    output shuffle_done, output status, input ready);
    modport sink   (input valid, input card_code, input card_valid, input cards_left,
                    input shuffle_done, input status, output ready);
endinterface

interface csd_cfg_if import csd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [PASS_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/csd_rem_unit.sv @@
// ----------------------------------------------------------------------------
// csd_rem_unit: iterative remainder of the random word by a small divisor
// Restoring division, REM_RADIX_BITS quotient bits per cycle.
// ----------------------------------------------------------------------------
module csd_rem_unit import csd_pkg::*;
#(
    parameter int DIV_W = 6
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] dividend,
    input  logic [DIV_W-1:0]  divisor,
    output logic              done,
    output logic [DIV_W-1:0]  rem
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [REM_CNT_W-1:0] cnt_reg;
    logic [REM_PAD_W-1:0] shift_reg;
    logic [DIV_W-1:0]     div_reg;
    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     rem_next;

    always_comb
    begin
        logic [DIV_W:0]   trial;
        logic [DIV_W-1:0] r;
        r = rem_reg;
        for (int i = 0; i < REM_RADIX_BITS; i++)
        begin
            trial = {r, shift_reg[REM_PAD_W-1-i]};
            if (trial >= {1'b0, div_reg})
                trial = trial - {1'b0, div_reg};
            r = trial[DIV_W-1:0];
        end
        rem_next = r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (cnt_reg == REM_CNT_W'(REM_STEPS - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == REM_CNT_W'(REM_STEPS - 1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= REM_PAD_W'(dividend);
            div_reg   <= divisor;
            rem_reg   <= '0;
        end
        else if (busy_reg)
        begin
            shift_reg <= shift_reg << REM_RADIX_BITS;
            rem_reg   <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

@@ sv/csd_card_store.sv @@
// ----------------------------------------------------------------------------
// csd_card_store: permutation store of card codes
// One write port, two registered read ports; per-entry valid bits make an
// unwritten entry read as its own index, so a reload clears them all at once.
// ----------------------------------------------------------------------------
module csd_card_store import csd_pkg::*;
#(
    parameter int NUM_CARDS = NUM_CARDS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         clear,
    input  logic                         we,
    input  logic [$clog2(NUM_CARDS)-1:0] waddr,
    input  logic [CODE_W-1:0]            wdata,
    input  logic [$clog2(NUM_CARDS)-1:0] raddr_a,
    input  logic [$clog2(NUM_CARDS)-1:0] raddr_b,
    output logic [CODE_W-1:0]            rdata_a,
    output logic [CODE_W-1:0]            rdata_b
);

    localparam int IDX_W = $clog2(NUM_CARDS);

    logic [CODE_W-1:0]    mem [NUM_CARDS];
    logic [NUM_CARDS-1:0] valid_reg;

    logic [CODE_W-1:0] mem_a_reg;
    logic [CODE_W-1:0] mem_b_reg;
    logic              vld_a_reg;
    logic              vld_b_reg;
    logic [IDX_W-1:0]  addr_a_reg;
    logic [IDX_W-1:0]  addr_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        mem_a_reg  <= mem[raddr_a];
        mem_b_reg  <= mem[raddr_b];
        vld_a_reg  <= valid_reg[raddr_a];
        vld_b_reg  <= valid_reg[raddr_b];
        addr_a_reg <= raddr_a;
        addr_b_reg <= raddr_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (clear)
            valid_reg <= '0;
        else if (we)
            valid_reg[waddr] <= 1'b1;
    end

    // untouched entries still hold the ordered deck
    assign rdata_a = vld_a_reg ? mem_a_reg : CODE_W'(addr_a_reg);
    assign rdata_b = vld_b_reg ? mem_b_reg : CODE_W'(addr_b_reg);

endmodule

@@ sv/card_shuffle_and_draw.sv @@
// ----------------------------------------------------------------------------
// card_shuffle_and_draw: deck store with Fisher-Yates shuffle and draw
// Top level: request sequencer, remainder unit and card store.
// ----------------------------------------------------------------------------
// Usage:
//   req  : one request per operation (new deck, shuffle step, draw).
//   rsp  : exactly one response per request, in request order.
//   cfg  : writes shuffle_passes; always ready, write only while idle.
// Sequence from request accept to response valid:
//   new deck, ignored shuffle, empty draw, unused code : straight to done
//   draw                                               : fetch, then pick
//   shuffle step                                       : remainder unit, then swap
//   (a 31-bit word retired 4 bits per cycle in the remainder unit,
//   followed by a two-port read and two single-port writes for the swap).
// The next request can be accepted as soon as the response turns valid.
// One request is in flight at a time; req.ready is low while it is worked on.
// A finished response waits in the output register; the next request is
// accepted meanwhile and holds in its last state until the output is free.
// Reset loads the ordered deck (valid bits cleared at once, no sweep),
// fills the deck, sets the cursor to the top and shuffle_passes to 9.
// ----------------------------------------------------------------------------
module card_shuffle_and_draw import csd_pkg::*;
#(
    parameter int NUM_CARDS = NUM_CARDS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    csd_cfg_if.sink   cfg,
    csd_in_if.sink    req,
    csd_out_if.source rsp
);

    localparam int IDX_W = $clog2(NUM_CARDS);
    localparam int PTR_W = $clog2(NUM_CARDS + 1);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DIV    = 7'b0000010,
        S_FETCH  = 7'b0000100,
        S_PICK   = 7'b0001000,
        S_WR_CUR = 7'b0010000,
        S_WR_J   = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [PTR_W-1:0]    ptr_reg;
    logic [IDX_W-1:0]    cursor_reg;
    logic [PASS_W-1:0]   passes_done_reg;
    logic [PASS_W-1:0]   shuffle_passes_reg;
    logic                draw_op_reg;
    logic [IDX_W-1:0]    j_reg;
    logic [CODE_W-1:0]   tmp_reg;
    logic [CODE_W-1:0]   res_code_reg;
    logic                res_valid_reg;
    logic [STATUS_W-1:0] res_status_reg;

    logic                out_valid_reg;
    logic [CODE_W-1:0]   out_code_reg;
    logic                out_card_valid_reg;
    logic [LEFT_W-1:0]   out_left_reg;
    logic                out_done_reg;
    logic [STATUS_W-1:0] out_status_reg;

    logic accept;
    logic complete;
    logic out_free;
    logic rem_start;
    logic rem_done;
    logic [PTR_W-1:0] rem_val;

    logic              store_clear;
    logic              store_we;
    logic [IDX_W-1:0]  store_waddr;
    logic [CODE_W-1:0] store_wdata;
    logic [IDX_W-1:0]  store_raddr_a;
    logic [CODE_W-1:0] store_rdata_a;
    logic [CODE_W-1:0] store_rdata_b;

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign accept    = req.valid && req.ready;
    assign complete  = (passes_done_reg >= shuffle_passes_reg);
    assign out_free  = !out_valid_reg || rsp.ready;
    assign rem_start = accept && (req.operation == OP_SHUFFLE) && !complete;

    assign store_clear   = accept && (req.operation == OP_NEW);
    assign store_we      = (state_reg == S_WR_CUR) || (state_reg == S_WR_J);
    assign store_waddr   = (state_reg == S_WR_CUR) ? cursor_reg : j_reg;
    assign store_wdata   = (state_reg == S_WR_CUR) ? store_rdata_b : tmp_reg;
    assign store_raddr_a = draw_op_reg ? ptr_reg[IDX_W-1:0] : cursor_reg;

    csd_rem_unit #(
        .DIV_W (PTR_W)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (req.random_word),
        .divisor  (PTR_W'(cursor_reg) + PTR_W'(1)),
        .done     (rem_done),
        .rem      (rem_val)
    );

    csd_card_store #(
        .NUM_CARDS (NUM_CARDS)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (store_clear),
        .we      (store_we),
        .waddr   (store_waddr),
        .wdata   (store_wdata),
        .raddr_a (store_raddr_a),
        .raddr_b (j_reg),
        .rdata_a (store_rdata_a),
        .rdata_b (store_rdata_b)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (rem_start)
                        state_next = S_DIV;
                    else if ((req.operation == OP_DRAW) && (ptr_reg != '0))
                        state_next = S_FETCH;
                    else
                        state_next = S_DONE;
                end
            end
            S_DIV:    state_next = rem_done ? S_FETCH : S_DIV;
            S_FETCH:  state_next = draw_op_reg ? S_PICK : S_WR_CUR;
            S_PICK:   state_next = S_DONE;
            S_WR_CUR: state_next = S_WR_J;
            S_WR_J:   state_next = S_DONE;
            S_DONE:   state_next = out_free ? S_IDLE : S_DONE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            ptr_reg            <= PTR_W'(NUM_CARDS);
            cursor_reg         <= IDX_W'(NUM_CARDS - 1);
            passes_done_reg    <= '0;
            shuffle_passes_reg <= PASSES_RESET;
            draw_op_reg        <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg.valid)
                shuffle_passes_reg <= cfg.data;

            if (accept)
            begin
                draw_op_reg <= (req.operation == OP_DRAW);
                if (req.operation == OP_NEW)
                begin
                    ptr_reg         <= PTR_W'(NUM_CARDS);
                    cursor_reg      <= IDX_W'(NUM_CARDS - 1);
                    passes_done_reg <= '0;
                end
                else if ((req.operation == OP_DRAW) && (ptr_reg != '0))
                    ptr_reg <= ptr_reg - 1'b1;
            end

            // advance the cursor; a pass ends after the swap at entry one
            if (state_reg == S_WR_J)
            begin
                if (cursor_reg == IDX_W'(1))
                begin
                    passes_done_reg <= passes_done_reg + 1'b1;
                    cursor_reg      <= IDX_W'(NUM_CARDS - 1);
                end
                else
                    cursor_reg <= cursor_reg - 1'b1;
            end

            if ((state_reg == S_DONE) && out_free)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_code_reg  <= '0;
            res_valid_reg <= 1'b0;
            if ((req.operation == OP_DRAW) && (ptr_reg == '0))
                res_status_reg <= ST_EMPTY;
            else if ((req.operation == OP_SHUFFLE) && complete)
                res_status_reg <= ST_IGNORED;
            else
                res_status_reg <= ST_OK;
        end

        if ((state_reg == S_DIV) && rem_done)
            j_reg <= rem_val[IDX_W-1:0];

        // hold the entry at the cursor until it moves to slot j
        if (state_reg == S_WR_CUR)
            tmp_reg <= store_rdata_a;

        if (state_reg == S_PICK)
        begin
            res_code_reg  <= store_rdata_a;
            res_valid_reg <= 1'b1;
        end

        if ((state_reg == S_DONE) && out_free)
        begin
            out_code_reg       <= res_code_reg;
            out_card_valid_reg <= res_valid_reg;
            out_left_reg       <= LEFT_W'(ptr_reg);
            out_done_reg       <= complete;
            out_status_reg     <= res_status_reg;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.card_code    = out_code_reg;
    assign rsp.card_valid   = out_card_valid_reg;
    assign rsp.cards_left   = out_left_reg;
    assign rsp.shuffle_done = out_done_reg;
    assign rsp.status       = out_status_reg;

endmodule

@@ tb/card_shuffle_and_draw_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// card_shuffle_and_draw_tb: self-checking bench for the shuffle and draw deck
// Runs a short table of directed requests, then randomized games of the form
// new deck, shuffle steps until done, then draws that may run past empty. Noise
// requests and early restarts are mixed in. Both handshake sides idle in random
// bursts. A local deck model predicts each response that the table does not give,
// and the bench compares each field.
module card_shuffle_and_draw_tb import csd_pkg::*; ();

    localparam int DECK          = NUM_CARDS_DEF;
    localparam int ITEM_TARGET   = 1650;
    localparam int TAIL_ITEMS    = 150;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int REPORT_MAX    = 10;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam logic ROW_REQUEST = 1'b0;
    localparam logic ROW_PASSES  = 1'b1;

    typedef struct packed {
        logic [CODE_W-1:0]   card_code;
        logic                card_valid;
        logic [LEFT_W-1:0]   cards_left;
        logic                shuffle_done;
        logic [STATUS_W-1:0] status;
    } deck_report_t;

    typedef struct packed {
        logic              kind;
        logic [OP_W-1:0]   op;
        logic [WORD_W-1:0] word;
        logic [PASS_W-1:0] passes;
        logic              typed;
        deck_report_t      report;
    } script_row_t;

    // kind, op, word, passes, typed, {code, valid, left, done, status}
    localparam script_row_t SCRIPT [21] = '{
        {ROW_REQUEST, OP_DRAW,    31'd0,          4'd0,  1'b1,
            6'd51, 1'b1, 6'd51, 1'b0, ST_OK},
        {ROW_REQUEST, OP_UNUSED,  31'h7FFF_FFFF,  4'd0,  1'b1,
            6'd0,  1'b0, 6'd51, 1'b0, ST_OK},
        {ROW_REQUEST, OP_NEW,     31'h7FFF_FFFF,  4'd0,  1'b1,
            6'd0,  1'b0, 6'd52, 1'b0, ST_OK},
        {ROW_REQUEST, OP_SHUFFLE, 31'd0,          4'd0,  1'b0, 16'd0},
        {ROW_REQUEST, OP_SHUFFLE, 31'h7FFF_FFFF,  4'd0,  1'b0, 16'd0},
        {ROW_REQUEST, OP_SHUFFLE, 31'h2AAA_AAAA,  4'd0,  1'b0, 16'd0},
        {ROW_REQUEST, OP_SHUFFLE, 31'h5555_5555,  4'd0,  1'b0, 16'd0},
        {ROW_REQUEST, OP_SHUFFLE, 31'd48,         4'd0,  1'b0, 16'd0},
        {ROW_REQUEST, OP_DRAW,    31'd0,          4'd0,  1'b0, 16'd0},
        {ROW_REQUEST, OP_DRAW,    31'h7FFF_FFFF,  4'd0,  1'b0, 16'd0},
        // shuffle step after draws have taken cards off the deck
        {ROW_REQUEST, OP_SHUFFLE, 31'h4000_0000,  4'd0,  1'b0, 16'd0},
        // zero passes: shuffle counts as complete at once
        {ROW_PASSES,  OP_NEW,     31'd0,          4'd0,  1'b0, 16'd0},
        {ROW_REQUEST, OP_SHUFFLE, 31'd123,        4'd0,  1'b1,
            6'd0,  1'b0, 6'd50, 1'b1, ST_IGNORED},
        {ROW_REQUEST, OP_DRAW,    31'd0,          4'd0,  1'b0, 16'd0},
        {ROW_REQUEST, OP_NEW,     31'd0,          4'd0,  1'b1,
            6'd0,  1'b0, 6'd52, 1'b1, ST_OK},
        {ROW_PASSES,  OP_NEW,     31'd0,          4'd15, 1'b0, 16'd0},
        {ROW_REQUEST, OP_SHUFFLE, 31'd5,          4'd0,  1'b0, 16'd0},
        {ROW_REQUEST, OP_UNUSED,  31'd0,          4'd0,  1'b0, 16'd0},
        // rewrite the pass count in the middle of a shuffle
        {ROW_PASSES,  OP_NEW,     31'd0,          4'd9,  1'b0, 16'd0},
        {ROW_REQUEST, OP_SHUFFLE, 31'h7FFF_FFFE,  4'd0,  1'b0, 16'd0},
        {ROW_REQUEST, OP_DRAW,    31'd0,          4'd0,  1'b0, 16'd0}
    };

    logic clk = 1'b0;
    logic rst_n;

    csd_in_if  req_ch ();
    csd_out_if rsp_ch ();
    csd_cfg_if cfg_ch ();

    card_shuffle_and_draw #(.NUM_CARDS(DECK)) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #5 clk = ~clk;

    // deck model state
    logic [CODE_W-1:0] deck_order [DECK];
    logic [6:0]        deck_top;
    logic [5:0]        cursor_pos;
    logic [PASS_W-1:0] passes_run;
    logic [PASS_W-1:0] passes_cfg;

    deck_report_t expected_reports [$];
    deck_report_t want_report;

    int requests_sent     = 0;
    int failures          = 0;
    int cycle_count       = 0;
    int calm_left         = 0;
    bit quiet_tail        = 1'b0;
    bit long_hold_pending = 1'b0;

    function automatic void load_ordered_deck();
        for (int k = 0; k < DECK; k++)
            deck_order[k] = CODE_W'(k);
        deck_top   = 7'(DECK);
        cursor_pos = 6'(DECK - 1);
        passes_run = '0;
    endfunction

    task automatic predict_deck_step(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] word,
                                     output deck_report_t r);
        int                cur;
        int                pick;
        logic [CODE_W-1:0] held;
        r = '0;
        r.status = ST_OK;
        case (op)
            OP_NEW: load_ordered_deck();
            OP_SHUFFLE:
            begin
                if (passes_run >= passes_cfg)
                    r.status = ST_IGNORED;
                else
                begin
                    cur = cursor_pos;
                    if (cur >= DECK || cur == 0)
                        cur = DECK - 1;
                    pick = int'(word % WORD_W'(cur + 1));
                    held = deck_order[cur];
                    deck_order[cur]  = deck_order[pick];
                    deck_order[pick] = held;
                    // the swap at cursor 1 closes a pass
                    if (cur == 1)
                    begin
                        passes_run = passes_run + 1'b1;
                        cursor_pos = 6'(DECK - 1);
                    end
                    else
                        cursor_pos = 6'(cur - 1);
                end
            end
            OP_DRAW:
            begin
                if (deck_top == 0 || deck_top > DECK)
                    r.status = ST_EMPTY;
                else
                begin
                    deck_top     = deck_top - 1'b1;
                    r.card_code  = deck_order[deck_top];
                    r.card_valid = 1'b1;
                end
            end
            default: ;
        endcase
        r.cards_left   = deck_top[LEFT_W-1:0];
        r.shuffle_done = (passes_run >= passes_cfg);
    endtask

    function automatic logic [WORD_W-1:0] draw_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return WORD_W'($urandom_range(0, 2 * DECK));
            default: return WORD_W'($urandom);
        endcase
    endfunction

    task automatic send_request(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] word,
                                input logic use_typed, input deck_report_t typed_report);
        int           gap;
        deck_report_t predicted;
        gap = 0;
        if (!quiet_tail)
        begin
            if (calm_left > 0)
                calm_left--;
            else if ($urandom_range(0, 9) == 0)
                calm_left = $urandom_range(10, 40);
            else if ($urandom_range(0, 2) == 0)
                gap = $urandom_range(1, 17);
        end
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.operation   <= op;
        req_ch.random_word <= word;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predict_deck_step(op, word, predicted);
        expected_reports.push_back(use_typed ? typed_report : predicted);
        if (op != OP_UNUSED)
            requests_sent++;
        if (requests_sent >= ITEM_TARGET - TAIL_ITEMS)
            quiet_tail = 1'b1;
    endtask

    // drop the request and wait until every response is back
    task automatic settle_requests();
        req_ch.valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_passes(input logic [PASS_W-1:0] passes);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= passes;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        passes_cfg = passes;
    endtask

    task automatic play_game(input logic [PASS_W-1:0] passes, input bit hold_output);
        int draws;
        int steps;
        int restart_at;
        steps      = 0;
        restart_at = (passes <= 3 && $urandom_range(0, 3) == 0) ? $urandom_range(5, 100) : -1;
        settle_requests();
        write_passes(passes);
        send_request(OP_NEW, draw_word(), 1'b0, '0);
        if (hold_output)
            long_hold_pending = 1'b1;
        while (passes_run < passes_cfg)
        begin
            steps++;
            if (steps == restart_at)
                send_request(OP_NEW, draw_word(), 1'b0, '0);
            else if ($urandom_range(0, 19) == 0)
                send_request(OP_W'($urandom_range(1, 3)), draw_word(), 1'b0, '0);
            else
                send_request(OP_SHUFFLE, draw_word(), 1'b0, '0);
        end
        // words past completion are ignored
        repeat ($urandom_range(0, 3))
            send_request(OP_SHUFFLE, draw_word(), 1'b0, '0);
        draws = $urandom_range(40, DECK + 6);
        repeat (draws)
        begin
            if ($urandom_range(0, 19) == 0)
                send_request(OP_W'($urandom_range(0, 3)), draw_word(), 1'b0, '0);
            else
                send_request(OP_DRAW, draw_word(), 1'b0, '0);
        end
    endtask

    // response side: ready bursts, stall bursts and one long hold-off
    initial
    begin
        forever
        begin
            if (long_hold_pending)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold_pending = 1'b0;
            end
            else if (quiet_tail || $urandom_range(0, 2) != 0)
            begin
                rsp_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
            else
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_reports.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("%0t: response with none pending: code=%0d valid=%0d left=%0d",
                             $realtime, rsp_ch.card_code, rsp_ch.card_valid, rsp_ch.cards_left);
            end
            else
            begin
                want_report = expected_reports.pop_front();
                if (rsp_ch.card_code !== want_report.card_code
                    || rsp_ch.card_valid !== want_report.card_valid
                    || rsp_ch.cards_left !== want_report.cards_left
                    || rsp_ch.shuffle_done !== want_report.shuffle_done
                    || rsp_ch.status !== want_report.status)
                begin
                    failures++;
                    // fields in order code, valid, left, done, status
                    if (failures <= REPORT_MAX)
                        $display(
                            "%0t: mismatch exp %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d",
                            $realtime, want_report.card_code, want_report.card_valid,
                            want_report.cards_left, want_report.shuffle_done,
                            want_report.status, rsp_ch.card_code, rsp_ch.card_valid,
                            rsp_ch.cards_left, rsp_ch.shuffle_done, rsp_ch.status);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("card_shuffle_and_draw_tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n              <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.operation   <= OP_NEW;
        req_ch.random_word <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.data        <= '0;
        passes_cfg = PASSES_RESET;
        load_ordered_deck();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < $size(SCRIPT); i++)
        begin
            if (SCRIPT[i].kind == ROW_PASSES)
            begin
                settle_requests();
                write_passes(SCRIPT[i].passes);
            end
            else
                send_request(SCRIPT[i].op, SCRIPT[i].word, SCRIPT[i].typed, SCRIPT[i].report);
        end

        // one full-length shuffle, then short games
        play_game(4'd15, 1'b1);
        while (requests_sent < ITEM_TARGET)
            play_game(($urandom_range(0, 5) == 0) ? 4'd0 : PASS_W'($urandom_range(1, 3)), 1'b0);

        settle_requests();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("card_shuffle_and_draw_tb: PASS");
        else
            $display("card_shuffle_and_draw_tb: FAIL");
        $finish;
    end

endmodule
